@@ design/tcq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcq_pkg
// shared codes and types of the timed command queue
// ----------------------------------------------------------------------------
package tcq_pkg;

    // request codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_BACK   = 3'd1;
    localparam logic [2:0] OP_FRONT  = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_DROP   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_SUCCESS = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_PAST    = 3'd2;
    localparam logic [2:0] ST_EXISTS  = 3'd3;
    localparam logic [2:0] ST_ON_TIME = 3'd4;
    localparam logic [2:0] ST_NOT_YET = 3'd5;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_DECIDE     = 7'b0000010,
        S_WALK_START = 7'b0000100,
        S_WALK       = 7'b0001000,
        S_INS_LINK   = 7'b0010000,
        S_DROP_LD    = 7'b0100000,
        S_DONE       = 7'b1000000
    } t_state;

endpackage

@@ design/timed_command_queue_unit.sv @@
// ----------------------------------------------------------------------------
// timed_command_queue_unit: time-ordered linked list queue over a node memory
// requests: one at a time; the input stalls until the result of the last request is loaded
// walk: a mid insert walks the list from the head's successor, one node per cycle
// reset: synchronous, empty list, all nodes free, no clearing pass needed
// ----------------------------------------------------------------------------
module timed_command_queue_unit
    import tcq_pkg::*;
#(
    parameter int NODES        = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_exec_time,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_current_time,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_head_valid,
    output logic [31:0] o_head_time,
    output logic [63:0] o_head_payload,
    output logic [5:0]  o_active_count,
    output logic [31:0] o_executed_count,
    output logic        o_is_full
);

    // node index bits and pointer bits (a pointer also holds the null code)
    localparam int IW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    // node memories, synchronous read into registered outputs
    logic [31:0]           r_mem_time [NODES];
    logic [PAYLOAD_BITS-1:0] r_mem_pay [NODES];
    logic [PW-1:0]         r_mem_link [NODES];
    logic [31:0]           r_q_time;
    logic [PAYLOAD_BITS-1:0] r_q_pay;
    logic [PW-1:0]         r_q_link;

    // control state
    t_state        r_state, n_state;
    logic [PW-1:0] r_free_head, n_free_head;
    logic [PW-1:0] r_fresh, n_fresh;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_count, n_count;
    logic [31:0]   r_done, n_done;
    logic          r_out_valid;

    // working registers
    logic [2:0]              r_op;
    logic [31:0]             r_t;
    logic [PAYLOAD_BITS-1:0] r_p;
    logic [31:0]             r_now;
    logic [31:0]             r_head_time, n_head_time;
    logic [PAYLOAD_BITS-1:0] r_head_pay, n_head_pay;
    logic [31:0]             r_tail_time, n_tail_time;
    logic [PW-1:0]           r_prev, n_prev;
    logic [PW-1:0]           r_curr, n_curr;
    logic [PW-1:0]           r_new, n_new;
    logic [PW-1:0]           r_next_free, n_next_free;
    logic [2:0]              r_status, n_status;

    // result registers
    logic [2:0]  r_o_status;
    logic        r_o_hv;
    logic [31:0] r_o_ht;
    logic [63:0] r_o_hp;
    logic [5:0]  r_o_cnt;
    logic [31:0] r_o_exec;
    logic        r_o_full;

    // memory access controls
    logic [IW-1:0] rd_addr;
    logic          we_data;
    logic [IW-1:0] wa_data;
    logic          we_link;
    logic [IW-1:0] wa_link;
    logic [PW-1:0] wd_link;

    logic accept;
    logic out_load;
    logic empty;
    logic full;
    logic fresh_hit;
    logic [PW-1:0] next_free_now;
    logic do_front;
    logic do_back;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign empty      = (r_head == NIL);
    assign full       = (r_free_head == NIL);

    // the free list is a stack of recycled nodes followed by the untouched
    // nodes fresh..NODES-1; a fresh node's successor is simply the next index
    assign fresh_hit     = (r_free_head == r_fresh);
    assign next_free_now = fresh_hit ? r_fresh + PW'(1) : r_q_link;

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_done      = r_done;
        n_head_time = r_head_time;
        n_head_pay  = r_head_pay;
        n_tail_time = r_tail_time;
        n_prev      = r_prev;
        n_curr      = r_curr;
        n_new       = r_new;
        n_next_free = r_next_free;
        n_status    = r_status;
        rd_addr     = r_head[IW-1:0];
        we_data     = 1'b0;
        wa_data     = r_free_head[IW-1:0];
        we_link     = 1'b0;
        wa_link     = r_free_head[IW-1:0];
        wd_link     = r_head;
        do_front    = 1'b0;
        do_back     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // drop needs the head's successor, a take needs the free successor
                if (i_op == OP_DROP) begin
                    rd_addr = r_head[IW-1:0];
                end else begin
                    rd_addr = r_free_head[IW-1:0];
                end
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_status = ST_SUCCESS;
                n_state  = S_DONE;
                unique case (r_op)
                    OP_INSERT: begin
                        priority if (r_now > r_t) begin
                            n_status = ST_PAST;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else if (empty) begin
                            do_front = 1'b1;
                        end else if (r_tail_time < r_t) begin
                            do_back = 1'b1;
                        end else if (r_head_time > r_t) begin
                            do_front = 1'b1;
                        end else if (r_head_time == r_t || r_tail_time == r_t) begin
                            n_status = ST_EXISTS;
                        end else begin
                            // strictly inside: walk from the head's successor
                            n_prev      = r_head;
                            n_next_free = next_free_now;
                            rd_addr     = r_head[IW-1:0];
                            n_state     = S_WALK_START;
                        end
                    end
                    OP_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            do_back = 1'b1;
                        end
                    end
                    OP_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            do_front = 1'b1;
                        end
                    end
                    OP_CHECK: begin
                        priority if (empty) begin
                            n_status = ST_NOT_YET;
                        end else if (r_now == r_head_time) begin
                            n_status = ST_ON_TIME;
                        end else if (r_now > r_head_time) begin
                            n_status = ST_PAST;
                        end else begin
                            n_status = ST_NOT_YET;
                        end
                    end
                    OP_DROP: begin
                        n_done = r_done + 32'd1;
                        if (!empty) begin
                            // old head goes on top of the free stack
                            we_link     = 1'b1;
                            wa_link     = r_head[IW-1:0];
                            wd_link     = r_free_head;
                            n_free_head = r_head;
                            n_count     = r_count - PW'(1);
                            if (r_count == PW'(1)) begin
                                n_head = NIL;
                                n_tail = NIL;
                            end else begin
                                n_head  = r_q_link;
                                rd_addr = r_q_link[IW-1:0];
                                n_state = S_DROP_LD;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_free_head = '0;
                        n_fresh     = '0;
                        n_head      = NIL;
                        n_tail      = NIL;
                        n_count     = '0;
                    end
                    default: begin
                    end
                endcase

                // take the free head and link it at either end
                if (do_front || do_back) begin
                    we_data     = 1'b1;
                    wa_data     = r_free_head[IW-1:0];
                    n_free_head = next_free_now;
                    n_count     = r_count + PW'(1);
                    if (fresh_hit) begin
                        n_fresh = r_fresh + PW'(1);
                    end
                end
                if (do_front) begin
                    we_link     = 1'b1;
                    wa_link     = r_free_head[IW-1:0];
                    wd_link     = r_head;
                    n_head      = r_free_head;
                    n_head_time = r_t;
                    n_head_pay  = r_p;
                    if (empty) begin
                        n_tail      = r_free_head;
                        n_tail_time = r_t;
                    end
                end
                if (do_back) begin
                    // the tail's own link is never followed, so it stays unwritten
                    if (empty) begin
                        n_head      = r_free_head;
                        n_head_time = r_t;
                        n_head_pay  = r_p;
                    end else begin
                        we_link = 1'b1;
                        wa_link = r_tail[IW-1:0];
                        wd_link = r_free_head;
                    end
                    n_tail      = r_free_head;
                    n_tail_time = r_t;
                end
            end

            S_WALK_START: begin
                n_curr  = r_q_link;
                rd_addr = r_q_link[IW-1:0];
                n_state = S_WALK;
            end

            S_WALK: begin
                // memory output holds time and link of the current node
                priority if (r_q_time < r_t) begin
                    n_prev  = r_curr;
                    n_curr  = r_q_link;
                    rd_addr = r_q_link[IW-1:0];
                end else if (r_q_time > r_t) begin
                    we_data     = 1'b1;
                    wa_data     = r_free_head[IW-1:0];
                    we_link     = 1'b1;
                    wa_link     = r_free_head[IW-1:0];
                    wd_link     = r_curr;
                    n_new       = r_free_head;
                    n_free_head = r_next_free;
                    n_count     = r_count + PW'(1);
                    if (fresh_hit) begin
                        n_fresh = r_fresh + PW'(1);
                    end
                    n_status = ST_SUCCESS;
                    n_state  = S_INS_LINK;
                end else begin
                    n_status = ST_EXISTS;
                    n_state  = S_DONE;
                end
            end

            S_INS_LINK: begin
                we_link = 1'b1;
                wa_link = r_prev[IW-1:0];
                wd_link = r_new;
                n_state = S_DONE;
            end

            S_DROP_LD: begin
                n_head_time = r_q_time;
                n_head_pay  = r_q_pay;
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // node memories
    always_ff @(posedge i_clk) begin
        if (we_data) begin
            r_mem_time[wa_data] <= r_t;
            r_mem_pay[wa_data]  <= r_p;
        end
        if (we_link) begin
            r_mem_link[wa_link] <= wd_link;
        end
        r_q_time <= r_mem_time[rd_addr];
        r_q_pay  <= r_mem_pay[rd_addr];
        r_q_link <= r_mem_link[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_done      <= n_done;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_t   <= i_exec_time;
            r_p   <= i_payload[PAYLOAD_BITS-1:0];
            r_now <= i_current_time;
        end
        r_head_time <= n_head_time;
        r_head_pay  <= n_head_pay;
        r_tail_time <= n_tail_time;
        r_prev      <= n_prev;
        r_curr      <= n_curr;
        r_new       <= n_new;
        r_next_free <= n_next_free;
        r_status    <= n_status;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_hv     <= !empty;
            r_o_ht     <= empty ? 32'd0 : r_head_time;
            r_o_hp     <= empty ? 64'd0 : 64'(r_head_pay);
            r_o_cnt    <= 6'(r_count);
            r_o_exec   <= r_done;
            r_o_full   <= full;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_head_valid     = r_o_hv;
    assign o_head_time      = r_o_ht;
    assign o_head_payload   = r_o_hp;
    assign o_active_count   = r_o_cnt;
    assign o_executed_count = r_o_exec;
    assign o_is_full        = r_o_full;

endmodule

@@ tb/timed_command_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_queue_unit_test
// drives directed and random requests into the timed command queue; checks each
// result against a node pool model kept here or a typed row's result, with random
// idling on both channels, one long result hold-off and a drain pause between phases
// ----------------------------------------------------------------------------
module timed_command_queue_unit_test;
    import tcq_pkg::*;

    localparam int         NODES           = 32;
    localparam logic [5:0] NIL             = 6'(NODES);
    // request codes the block does not define, expected to change nothing
    localparam logic [2:0] OP_SPARE_6      = 3'd6;
    localparam logic [2:0] OP_SPARE_7      = 3'd7;
    localparam int         CLK_PERIOD      = 10;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         LONG_HOLD       = 300;
    localparam int         DRAIN_CYCLES    = 60;
    localparam int         ITEMS_PER_PHASE = 190;

    // what the block reports after each request
    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [31:0] head_time;
        logic [63:0] head_payload;
        logic [5:0]  active_count;
        logic [31:0] executed_count;
        logic        is_full;
    } queue_view_t;

    // one line of the directed table, repeated reps times
    typedef struct {
        logic [2:0]  op;
        logic [31:0] exec_time;
        logic [63:0] payload;
        logic [31:0] now;
        int          reps;
        bit          typed;
        queue_view_t want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_op;
    logic [31:0] i_exec_time;
    logic [63:0] i_payload;
    logic [31:0] i_current_time;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic        o_head_valid;
    logic [31:0] o_head_time;
    logic [63:0] o_head_payload;
    logic [5:0]  o_active_count;
    logic [31:0] o_executed_count;
    logic        o_is_full;

    timed_command_queue_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_exec_time      (i_exec_time),
        .i_payload        (i_payload),
        .i_current_time   (i_current_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_head_valid     (o_head_valid),
        .o_head_time      (o_head_time),
        .o_head_payload   (o_head_payload),
        .o_active_count   (o_active_count),
        .o_executed_count (o_executed_count),
        .o_is_full        (o_is_full)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_req;
    int mismatches;
    int quiet_cycles;

    // results still owed by the block, oldest first
    queue_view_t expected_views[$];

    // ------------------------------------------------------------------------
    // node pool model: active list in time order plus free list
    // ------------------------------------------------------------------------
    logic [31:0] slot_time[NODES];
    logic [63:0] slot_data[NODES];
    logic [5:0]  slot_next[NODES];
    logic [5:0]  free_top;
    logic [5:0]  list_head;
    logic [5:0]  list_tail;
    logic [5:0]  list_len;
    logic [31:0] drops_done;

    // every node back on the free list in index order
    function automatic void relink_pool();
        for (int i = 0; i < NODES - 1; i++) slot_next[i] = 6'(i + 1);
        slot_next[NODES - 1] = NIL;
        free_top  = 6'd0;
        list_head = NIL;
        list_tail = NIL;
        list_len  = 6'd0;
    endfunction

    // pops a free node and fills it, NIL when the pool is used up
    function automatic logic [5:0] take_slot(input logic [31:0] t, input logic [63:0] p);
        logic [5:0] n;
        n = free_top;
        if (n >= NIL) return NIL;
        free_top     = slot_next[n];
        slot_time[n] = t;
        slot_data[n] = p;
        return n;
    endfunction

    function automatic logic [2:0] link_front(input logic [31:0] t, input logic [63:0] p);
        logic [5:0] n;
        n = take_slot(t, p);
        if (n == NIL) return ST_FULL;
        slot_next[n] = list_head;
        list_head    = n;
        if (list_tail == NIL) list_tail = n;
        list_len++;
        return ST_SUCCESS;
    endfunction

    function automatic logic [2:0] link_back(input logic [31:0] t, input logic [63:0] p);
        logic [5:0] n;
        n = take_slot(t, p);
        if (n == NIL) return ST_FULL;
        slot_next[n] = NIL;
        if (list_tail == NIL) list_head = n;
        else slot_next[list_tail] = n;
        list_tail = n;
        list_len++;
        return ST_SUCCESS;
    endfunction

    function automatic queue_view_t make_view(input logic [2:0] st, input logic hv,
                                              input logic [31:0] ht, input logic [63:0] hp,
                                              input logic [5:0] cnt, input logic [31:0] ex,
                                              input logic full);
        queue_view_t v;
        v.status         = st;
        v.head_valid     = hv;
        v.head_time      = ht;
        v.head_payload   = hp;
        v.active_count   = cnt;
        v.executed_count = ex;
        v.is_full        = full;
        return v;
    endfunction

    // applies one request to the pool and returns what the block must report
    function automatic queue_view_t apply_request(input logic [2:0] op, input logic [31:0] t,
                                                  input logic [63:0] p, input logic [31:0] now);
        logic [2:0] st;
        logic [5:0] prev;
        logic [5:0] cur;
        logic [5:0] n;
        logic       settled;
        logic       hv;
        int         i;
        st = ST_SUCCESS;
        case (op)
            OP_INSERT: begin
                // past time wins over full, full over ordering
                if (now > t) st = ST_PAST;
                else if (free_top >= NIL) st = ST_FULL;
                else if (list_head == NIL) st = link_front(t, p);
                else if (slot_time[list_tail] < t) st = link_back(t, p);
                else if (slot_time[list_head] > t) st = link_front(t, p);
                else if (slot_time[list_head] == t || slot_time[list_tail] == t) st = ST_EXISTS;
                else begin
                    // walk from the second entry to the first later time
                    prev    = list_head;
                    cur     = slot_next[prev];
                    settled = 1'b0;
                    for (i = 1; i < list_len && cur != NIL && !settled; i++) begin
                        if (slot_time[cur] < t) begin
                            prev = cur;
                            cur  = slot_next[cur];
                        end else if (slot_time[cur] > t) begin
                            n               = take_slot(t, p);
                            slot_next[n]    = cur;
                            slot_next[prev] = n;
                            list_len++;
                            settled = 1'b1;
                        end else begin
                            st      = ST_EXISTS;
                            settled = 1'b1;
                        end
                    end
                    if (!settled) st = link_back(t, p);
                end
            end
            OP_BACK:  st = link_back(t, p);
            OP_FRONT: st = link_front(t, p);
            OP_CHECK: begin
                st = ST_NOT_YET;
                if (list_head != NIL) begin
                    if (now == slot_time[list_head]) st = ST_ON_TIME;
                    else if (now > slot_time[list_head]) st = ST_PAST;
                end
            end
            OP_DROP: begin
                // an empty list still counts the drop
                n = list_head;
                if (n != NIL) begin
                    list_head = slot_next[n];
                    if (list_head == NIL) list_tail = NIL;
                    slot_next[n] = free_top;
                    free_top     = n;
                    list_len--;
                end
                drops_done++;
            end
            OP_CLEAR: relink_pool();
            default: ;
        endcase
        hv = (list_head != NIL);
        return make_view(st, hv, hv ? slot_time[list_head] : 32'd0,
                         hv ? slot_data[list_head] : 64'd0, list_len, drops_done,
                         free_top >= NIL);
    endfunction

    function automatic stim_row_t stim(input logic [2:0] op, input logic [31:0] t,
                                       input logic [63:0] p, input logic [31:0] now,
                                       input int reps, input bit typed, input queue_view_t want);
        stim_row_t r;
        r.op        = op;
        r.exec_time = t;
        r.payload   = p;
        r.now       = now;
        r.reps      = reps;
        r.typed     = typed;
        r.want      = want;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side: offer one item at a falling edge, hold it until accepted
    // ------------------------------------------------------------------------
    task automatic offer(input logic [2:0] op, input logic [31:0] t, input logic [63:0] p,
                         input logic [31:0] now, input bit typed, input queue_view_t want);
        queue_view_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_exec_time    <= t;
        i_payload      <= p;
        i_current_time <= now;
        do @(posedge i_clk); while (o_in_stall);
        // accepted at this edge, the model steps here
        got = apply_request(op, t, p, now);
        expected_views.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall per cycle, or a long hold when requested
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        queue_view_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_views.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with no item outstanding, expected none actual status %0h",
                         $time, o_status);
            end else begin
                want = expected_views.pop_front();
                compare_field("status", want.status, o_status);
                compare_field("head_valid", want.head_valid, o_head_valid);
                compare_field("head_time", want.head_time, o_head_time);
                compare_field("head_payload", want.head_payload, o_head_payload);
                compare_field("active_count", want.active_count, o_active_count);
                compare_field("executed_count", want.executed_count, o_executed_count);
                compare_field("is_full", want.is_full, o_is_full);
            end
        end
    end

    // watchdog: too long with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL timed_command_queue_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: reset, directed table, then three random phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t   rows[$];
        queue_view_t none;
        queue_view_t lone;
        queue_view_t packed_full;
        int          send_pct[3];
        int          recv_pct[3];
        int          pick;
        logic [2:0]  op;
        logic [31:0] t;
        logic [31:0] now;
        logic [31:0] epoch;
        logic [63:0] p;
        bit          draining;

        send_pct = '{13, 83, 0};
        recv_pct = '{83, 13, 0};
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_CHECK;
        i_exec_time    = 32'd0;
        i_payload      = 64'd0;
        i_current_time = 32'd0;
        send_idle_pct  = send_pct[0];
        recv_idle_pct  = recv_pct[0];
        long_hold_req  = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        draining       = 1'b0;
        epoch          = $urandom;

        // model starts from the reset state of the block
        for (int i = 0; i < NODES; i++) begin
            slot_time[i] = 32'd0;
            slot_data[i] = 64'd0;
        end
        relink_pool();
        drops_done = 32'd0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; typed rows carry their result, the rest go to the model
        none        = '0;
        lone        = make_view(ST_SUCCESS, 1'b1, 32'hFFFF_FFFF, '1, 6'd1, 32'd1, 1'b0);
        packed_full = make_view(ST_FULL, 1'b1, 32'h8000_0001, 64'h0123_4567_89AB_CDEF,
                                6'd32, 32'd2, 1'b1);
        // empty list: check is not yet, drop still counts, spare codes do nothing
        rows.push_back(stim(OP_CHECK, 32'd0, 64'd0, 32'd0, 1, 1'b1,
                            make_view(ST_NOT_YET, 1'b0, 32'd0, 64'd0, 6'd0, 32'd0, 1'b0)));
        rows.push_back(stim(OP_DROP, 32'd0, 64'd0, 32'd0, 1, 1'b1,
                            make_view(ST_SUCCESS, 1'b0, 32'd0, 64'd0, 6'd0, 32'd1, 1'b0)));
        rows.push_back(stim(OP_SPARE_6, 32'd9, 64'd9, 32'd9, 1, 1'b1,
                            make_view(ST_SUCCESS, 1'b0, 32'd0, 64'd0, 6'd0, 32'd1, 1'b0)));
        rows.push_back(stim(OP_SPARE_7, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 1, 1'b0, none));
        // past time on an empty list
        rows.push_back(stim(OP_INSERT, 32'd5, 64'd1, 32'd6, 1, 1'b1,
                            make_view(ST_PAST, 1'b0, 32'd0, 64'd0, 6'd0, 32'd1, 1'b0)));
        // insert into empty list at the top time, then the same time again
        rows.push_back(stim(OP_INSERT, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 1, 1'b1, lone));
        lone.status = ST_EXISTS;
        rows.push_back(stim(OP_INSERT, 32'hFFFF_FFFF, 64'd2, 32'd0, 1, 1'b1, lone));
        lone.status = ST_ON_TIME;
        rows.push_back(stim(OP_CHECK, 32'd0, 64'd0, 32'hFFFF_FFFF, 1, 1'b1, lone));
        lone.status = ST_NOT_YET;
        rows.push_back(stim(OP_CHECK, 32'd0, 64'd0, 32'd0, 1, 1'b1, lone));
        // ordering: front by time, walk into the middle, equal times in the walk and at the head
        rows.push_back(stim(OP_INSERT, 32'd0, 64'd0, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_CHECK, 32'd0, 64'd0, 32'd1, 1, 1'b0, none));
        rows.push_back(stim(OP_INSERT, 32'd1000, 64'hA5A5_A5A5_5A5A_5A5A, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_INSERT, 32'd500, 64'h5A5A_5A5A_A5A5_A5A5, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_INSERT, 32'd1000, 64'd3, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_INSERT, 32'd0, 64'd4, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_FRONT, 32'd7, 64'd5, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_BACK, 32'd3, 64'd6, 32'd0, 1, 1'b0, none));
        rows.push_back(stim(OP_DROP, 32'd0, 64'd0, 32'd0, 1, 1'b0, none));
        // clear keeps the executed count
        rows.push_back(stim(OP_CLEAR, 32'd0, 64'd0, 32'd0, 1, 1'b1,
                            make_view(ST_SUCCESS, 1'b0, 32'd0, 64'd0, 6'd0, 32'd2, 1'b0)));
        // fill the pool, then every kind of insert on a full pool
        rows.push_back(stim(OP_BACK, 32'h8000_0001, 64'h0123_4567_89AB_CDEF, 32'd0,
                            NODES, 1'b0, none));
        rows.push_back(stim(OP_BACK, 32'd1, 64'd1, 32'd0, 1, 1'b1, packed_full));
        rows.push_back(stim(OP_FRONT, 32'd1, 64'd1, 32'd0, 1, 1'b1, packed_full));
        rows.push_back(stim(OP_INSERT, 32'hFFFF_FFFF, 64'd1, 32'd0, 1, 1'b1, packed_full));
        // past time is reported even when full
        packed_full.status = ST_PAST;
        rows.push_back(stim(OP_INSERT, 32'd0, 64'd1, 32'd1, 1, 1'b1, packed_full));
        // drain past empty, then clear
        rows.push_back(stim(OP_DROP, 32'd0, 64'd0, 32'd0, NODES + 1, 1'b0, none));
        rows.push_back(stim(OP_CLEAR, 32'd0, 64'd0, 32'd0, 1, 1'b0, none));

        foreach (rows[r]) begin
            repeat (rows[r].reps) begin
                offer(rows[r].op, rows[r].exec_time, rows[r].payload, rows[r].now,
                      rows[r].typed && rows[r].reps == 1, rows[r].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = send_pct[phase];
            recv_idle_pct = recv_pct[phase];
            // last phase: results held back while requests keep coming
            if (phase == 2) long_hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // grow until full, then drain until empty
                if (list_len >= NIL) draining = 1'b1;
                else if (list_len == 6'd0) draining = 1'b0;
                if (list_len == 6'd0 && $urandom_range(3) == 0) epoch = $urandom;

                p = {$urandom, $urandom};
                // narrow time window so equal times and deep walks happen often
                t = ($urandom_range(9) == 0) ? $urandom : epoch + $urandom_range(47);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: now = t - $urandom_range(3);
                    6, 7:             now = epoch;
                    8:                now = t + 32'd1 + $urandom_range(5);
                    default:          now = $urandom;
                endcase

                pick = $urandom_range(99);
                if (pick < 1) op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
                else if (pick < 2) op = OP_CLEAR;
                else if (pick < (draining ? 45 : 14)) op = OP_DROP;
                else if (pick < 58) op = OP_INSERT;
                else if (pick < 66) op = OP_BACK;
                else if (pick < 74) op = OP_FRONT;
                else op = OP_CHECK;

                // check against times around the present head
                if (op == OP_CHECK && list_head != NIL) begin
                    case ($urandom_range(3))
                        0:       now = slot_time[list_head];
                        1:       now = slot_time[list_head] - 32'd1;
                        2:       now = slot_time[list_head] + 32'd1;
                        default: ;
                    endcase
                    epoch = epoch + $urandom_range(3);
                end

                offer(op, t, p, now, 1'b0, none);
            end
            // sender pauses until every owed result is in
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (expected_views.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("PASS timed_command_queue_unit");
        end else begin
            $display("FAIL timed_command_queue_unit");
        end
        $finish;
    end

endmodule
